/* sv/ipf_pkg.sv */
`default_nettype none
package ipf_pkg;

    localparam int IPF_MAX_FIELD = 64;

    localparam int DIG_N = 22;
    localparam int DIG_W = DIG_N * 4;
    localparam int MAG_W = 66;

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_OCT  = 3'd2;
    localparam logic [2:0] OP_HEXL = 3'd3;
    localparam logic [2:0] OP_HEXU = 3'd4;

    localparam logic [1:0] SZ_INT   = 2'd0;
    localparam logic [1:0] SZ_SHORT = 2'd1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CASE_OFS = 8'd32;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  size_mode;
        logic [63:0] value;
        logic [6:0]  field_width;
        logic        has_precision;
        logic [5:0]  min_digits;
        logic        left_justify;
        logic        force_sign;
        logic        space_sign;
        logic        alt_form;
        logic        zero_fill;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_LAYOUT,
        ST_PADL,
        ST_SIGN,
        ST_PFX0,
        ST_PFX1,
        ST_ZERO,
        ST_DIGIT,
        ST_PADR
    } t_state;

endpackage
`default_nettype wire

/* sv/integer_printf_formatter.sv */
// Integer field formatter, printf style (%d %u %o %x %X).
// Input channel: i_in_valid / o_in_stall with i_in_data (ipf_pkg::t_in). One transfer
// carries one conversion. The block takes one item at a time; o_in_stall is high from
// the transfer until the last character of that field has been loaded into the output
// register.
// Output channel: o_out_valid / i_out_stall with o_out_data (ipf_pkg::t_out), one
// character per transfer, last_char set on the final one. At most MAX_FIELD characters.
// Per item: digit conversion runs one bit per cycle for decimal and one digit per cycle
// for hex (both by operand size) and octal (always all 22 digits). A leading-zero scan
// and the layout step follow, then the field goes out one character per cycle while the
// output is not stalled, passing over empty sections. The serial binary-to-BCD shift and
// the one-character output register set the pace of the block.
// A stall on the output holds the current character and pauses emission; the next
// item is taken once emission is done, even while the last character still waits.
// Reset (synchronous, active low) returns to idle and empties the output register.
`default_nettype none
module integer_printf_formatter #(
    parameter int MAX_FIELD = ipf_pkg::IPF_MAX_FIELD
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire ipf_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output ipf_pkg::t_out     o_out_data
);
    import ipf_pkg::*;

    localparam int RW = $clog2(MAX_FIELD + 1);

    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    t_out r_out, n_out;

    logic [DIG_W-1:0] r_dig, n_dig;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic [6:0] r_cnt, n_cnt;
    logic [4:0] r_nd, n_nd;
    logic [6:0] r_pad, n_pad;
    logic [6:0] r_pz, n_pz;
    logic [RW-1:0] r_rem, n_rem;
    logic r_is_dec, n_is_dec;
    logic r_is_oct, n_is_oct;
    logic r_is_hex, n_is_hex;
    logic r_lower, n_lower;
    logic r_sign_on, n_sign_on;
    logic [7:0] r_sign_ch, n_sign_ch;
    logic [6:0] r_width, n_width;
    logic r_has_prec, n_has_prec;
    logic [5:0] r_prec, n_prec;
    logic r_left, n_left;
    logic r_alt, n_alt;
    logic r_zf, n_zf;
    logic r_plen, n_plen;

    logic [2:0] w_op;
    logic [63:0] w_m, w_negv, w_abs, w_align;
    logic w_sb, w_neg;
    logic [DIG_W-1:0] w_dab;
    logic [3:0] w_msd;
    logic [6:0] w_pz0, w_pz1, w_base, w_tot0, w_pzf, w_total, w_padv, w_len;
    logic w_plen_on, w_msd_zero, w_slot, w_emit;
    logic [7:0] w_char;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_op = (i_in_data.op > OP_HEXU) ? OP_HEXU : i_in_data.op;
        unique case (i_in_data.size_mode)
            SZ_SHORT: begin
                w_m  = {48'b0, i_in_data.value[15:0]};
                w_sb = i_in_data.value[15];
            end
            SZ_INT: begin
                w_m  = {32'b0, i_in_data.value[31:0]};
                w_sb = i_in_data.value[31];
            end
            default: begin
                w_m  = i_in_data.value;
                w_sb = i_in_data.value[63];
            end
        endcase
        w_neg  = (w_op == OP_SDEC) && w_sb;
        w_negv = ~w_m + 64'd1;
        unique case (i_in_data.size_mode)
            SZ_SHORT: begin
                w_abs   = w_neg ? {48'b0, w_negv[15:0]} : w_m;
                w_align = {w_abs[15:0], 48'b0};
            end
            SZ_INT: begin
                w_abs   = w_neg ? {32'b0, w_negv[31:0]} : w_m;
                w_align = {w_abs[31:0], 32'b0};
            end
            default: begin
                w_abs   = w_neg ? w_negv : w_m;
                w_align = w_abs;
            end
        endcase
    end

    // add-3 correction of every BCD digit before the shift
    always_comb begin
        for (int k = 0; k < DIG_N; k++) begin
            w_dab[k*4 +: 4] = (r_dig[k*4 +: 4] >= 4'd5) ? r_dig[k*4 +: 4] + 4'd3
                                                        : r_dig[k*4 +: 4];
        end
    end

    assign w_msd      = r_dig[DIG_W-1 -: 4];
    assign w_msd_zero = (w_msd == 4'd0);

    always_comb begin
        w_pz0 = (r_has_prec && {1'b0, r_prec} > {2'b0, r_nd})
              ? {1'b0, r_prec} - {2'b0, r_nd} : 7'd0;
        w_pz1 = (r_alt && r_is_oct && w_pz0 == 7'd0 && !w_msd_zero) ? 7'd1 : w_pz0;
        w_plen_on = r_alt && r_is_hex && !w_msd_zero;
        w_base = {6'b0, r_sign_on} + (w_plen_on ? 7'd2 : 7'd0) + {2'b0, r_nd};
        w_tot0 = w_base + w_pz1;
        if (r_zf && !r_has_prec && !r_left && r_width > w_tot0) begin
            w_pzf   = r_width - w_base;
            w_total = r_width;
        end else begin
            w_pzf   = w_pz1;
            w_total = w_tot0;
        end
        w_padv = (r_width > w_total) ? r_width - w_total : 7'd0;
        w_len  = w_total + w_padv;
    end

    assign w_slot = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        n_dig = r_dig;
        n_mag = r_mag;
        n_cnt = r_cnt;
        n_nd = r_nd;
        n_pad = r_pad;
        n_pz = r_pz;
        n_rem = r_rem;
        n_is_dec = r_is_dec;
        n_is_oct = r_is_oct;
        n_is_hex = r_is_hex;
        n_lower = r_lower;
        n_sign_on = r_sign_on;
        n_sign_ch = r_sign_ch;
        n_width = r_width;
        n_has_prec = r_has_prec;
        n_prec = r_prec;
        n_left = r_left;
        n_alt = r_alt;
        n_zf = r_zf;
        n_plen = r_plen;
        w_emit = 1'b0;
        w_char = CH_SPACE;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CONV;
                    n_dig = '0;
                    n_is_dec = (w_op == OP_SDEC) || (w_op == OP_UDEC);
                    n_is_oct = (w_op == OP_OCT);
                    n_is_hex = (w_op == OP_HEXL) || (w_op == OP_HEXU);
                    n_lower = (w_op == OP_HEXL);
                    n_sign_on = w_neg || ((w_op == OP_SDEC) &&
                                (i_in_data.force_sign || i_in_data.space_sign));
                    n_sign_ch = w_neg ? CH_MINUS
                              : (i_in_data.force_sign ? CH_PLUS : CH_SPACE);
                    n_width = i_in_data.field_width;
                    n_has_prec = i_in_data.has_precision;
                    n_prec = i_in_data.min_digits;
                    n_left = i_in_data.left_justify;
                    n_alt = i_in_data.alt_form;
                    n_zf = i_in_data.zero_fill;
                    if (w_op == OP_OCT) begin
                        n_mag = {2'b0, w_abs};
                        n_cnt = 7'(DIG_N);
                    end else begin
                        n_mag = {w_align, 2'b0};
                        unique case (i_in_data.size_mode)
                            SZ_SHORT: n_cnt = 7'd16;
                            SZ_INT:   n_cnt = 7'd32;
                            default:  n_cnt = 7'd64;
                        endcase
                        if (w_op != OP_SDEC && w_op != OP_UDEC) begin
                            n_cnt = n_cnt >> 2;
                        end
                    end
                end
            end
            ST_CONV: begin
                if (r_is_dec) begin
                    n_dig = {w_dab[DIG_W-2:0], r_mag[MAG_W-1]};
                    n_mag = r_mag << 1;
                end else if (r_is_oct) begin
                    n_dig = {r_dig[DIG_W-5:0], 1'b0, r_mag[MAG_W-1 -: 3]};
                    n_mag = r_mag << 3;
                end else begin
                    n_dig = {r_dig[DIG_W-5:0], r_mag[MAG_W-1 -: 4]};
                    n_mag = r_mag << 4;
                end
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_state = ST_NORM;
                    n_nd = 5'(DIG_N);
                end
            end
            ST_NORM: begin
                if (r_nd > 5'd1 && w_msd_zero) begin
                    n_dig = {r_dig[DIG_W-5:0], 4'b0};
                    n_nd = r_nd - 5'd1;
                end else begin
                    n_state = ST_LAYOUT;
                end
            end
            ST_LAYOUT: begin
                n_pz = w_pzf;
                n_pad = w_padv;
                n_plen = w_plen_on;
                n_rem = (int'(w_len) > MAX_FIELD) ? RW'(MAX_FIELD) : RW'(w_len);
                n_state = ST_PADL;
            end
            ST_PADL: begin
                if (r_left || r_pad == 7'd0) begin
                    n_state = ST_SIGN;
                end else if (w_slot) begin
                    w_emit = 1'b1;
                    w_char = CH_SPACE;
                    n_pad = r_pad - 7'd1;
                end
            end
            ST_SIGN: begin
                if (!r_sign_on) begin
                    n_state = ST_PFX0;
                end else if (w_slot) begin
                    w_emit = 1'b1;
                    w_char = r_sign_ch;
                    n_sign_on = 1'b0;
                end
            end
            ST_PFX0: begin
                if (!r_plen) begin
                    n_state = ST_ZERO;
                end else if (w_slot) begin
                    w_emit = 1'b1;
                    w_char = CH_ZERO;
                    n_state = ST_PFX1;
                end
            end
            ST_PFX1: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    w_char = CH_X + (r_lower ? CASE_OFS : 8'd0);
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (r_pz == 7'd0) begin
                    n_state = ST_DIGIT;
                end else if (w_slot) begin
                    w_emit = 1'b1;
                    w_char = CH_ZERO;
                    n_pz = r_pz - 7'd1;
                end
            end
            ST_DIGIT: begin
                if (r_nd == 5'd0) begin
                    n_state = ST_PADR;
                end else if (w_slot) begin
                    w_emit = 1'b1;
                    w_char = (w_msd < 4'd10) ? CH_ZERO + {4'b0, w_msd}
                           : CH_A + {4'b0, w_msd} - 8'd10 + (r_lower ? CASE_OFS : 8'd0);
                    n_dig = {r_dig[DIG_W-5:0], 4'b0};
                    n_nd = r_nd - 5'd1;
                end
            end
            ST_PADR: begin
                if (!r_left || r_pad == 7'd0) begin
                    n_state = ST_IDLE;
                end else if (w_slot) begin
                    w_emit = 1'b1;
                    w_char = CH_SPACE;
                    n_pad = r_pad - 7'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out.out_char = w_char;
            n_out.last_char = (r_rem == RW'(1));
            n_rem = r_rem - RW'(1);
            if (r_rem == RW'(1)) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_dig <= n_dig;
        r_mag <= n_mag;
        r_cnt <= n_cnt;
        r_nd <= n_nd;
        r_pad <= n_pad;
        r_pz <= n_pz;
        r_rem <= n_rem;
        r_is_dec <= n_is_dec;
        r_is_oct <= n_is_oct;
        r_is_hex <= n_is_hex;
        r_lower <= n_lower;
        r_sign_on <= n_sign_on;
        r_sign_ch <= n_sign_ch;
        r_width <= n_width;
        r_has_prec <= n_has_prec;
        r_prec <= n_prec;
        r_left <= n_left;
        r_alt <= n_alt;
        r_zf <= n_zf;
        r_plen <= n_plen;
    end

`ifndef SYNTHESIS
    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_CONV))
        else $error("accepted item did not start conversion");

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PADL || r_state == ST_SIGN || r_state == ST_PFX0 ||
         r_state == ST_PFX1 || r_state == ST_ZERO || r_state == ST_DIGIT) |-> (r_rem != '0))
        else $error("emission running with no characters left");

    a_norm_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM) |-> (r_nd != 5'd0))
        else $error("digit count reached zero during scan");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_rem == RW'(1)) |=> (r_state == ST_IDLE && o_out_valid && o_out_data.last_char))
        else $error("final character did not end the item");

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || !i_out_stall))
        else $error("character produced into an occupied output register");
`endif

endmodule
`default_nettype wire

/* verif/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipf_pkg::*;

    localparam int RANDOM_ITEMS = 133;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [1:0] SZ_LONG    = 2'd2;
    localparam logic [1:0] SZ_UNKNOWN = 2'd3;

    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_LEFT  = 5'b10000;
    localparam logic [4:0] F_PLUS  = 5'b01000;
    localparam logic [4:0] F_SPACE = 5'b00100;
    localparam logic [4:0] F_ALT   = 5'b00010;
    localparam logic [4:0] F_ZERO  = 5'b00001;

    localparam int NO_PREC = -1;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    class format_scoreboard;
        t_out pending_chars[$];
        int   fail_count;
        int   char_count;

        function void report(string msg);
            fail_count++;
            if (fail_count <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // Expected characters of one conversion, capped at the field limit.
        function void format_field(t_in req);
            logic [2:0]  op;
            logic [63:0] mask;
            logic [63:0] sign_bit;
            logic [63:0] mag;
            logic [63:0] base;
            logic [7:0]  sign_ch;
            logic [7:0]  case_ofs;
            logic [7:0]  digit_ch[$];
            logic [7:0]  field[$];
            logic [3:0]  d;
            bit          has_sign;
            int          nd;
            int          zeros;
            int          plen;
            int          total;
            int          width;
            int          pad;
            int          n;

            op = (req.op > OP_HEXU) ? OP_HEXU : req.op;
            case (req.size_mode)
                SZ_INT: begin
                    mask     = 64'h0000_0000_FFFF_FFFF;
                    sign_bit = 64'h0000_0000_8000_0000;
                end
                SZ_SHORT: begin
                    mask     = 64'h0000_0000_0000_FFFF;
                    sign_bit = 64'h0000_0000_0000_8000;
                end
                default: begin
                    mask     = '1;
                    sign_bit = 64'h8000_0000_0000_0000;
                end
            endcase
            mag      = req.value & mask;
            has_sign = 1'b0;
            sign_ch  = CH_SPACE;
            if (op == OP_SDEC) begin
                if ((mag & sign_bit) != 64'd0) begin
                    mag      = (~mag + 64'd1) & mask;
                    sign_ch  = CH_MINUS;
                    has_sign = 1'b1;
                end else if (req.force_sign) begin
                    sign_ch  = CH_PLUS;
                    has_sign = 1'b1;
                end else if (req.space_sign) begin
                    has_sign = 1'b1;
                end
            end

            base     = (op <= OP_UDEC) ? 64'd10 : ((op == OP_OCT) ? 64'd8 : 64'd16);
            case_ofs = (op == OP_HEXL) ? CASE_OFS : 8'd0;
            do begin
                d = 4'(mag % base);
                if (d < 4'd10) begin
                    digit_ch.push_front(CH_ZERO + 8'(d));
                end else begin
                    digit_ch.push_front(CH_A + 8'(d - 4'd10) + case_ofs);
                end
                mag = mag / base;
            end while (mag != 64'd0);
            nd = digit_ch.size();

            zeros = (req.has_precision && int'(req.min_digits) > nd) ?
                    int'(req.min_digits) - nd : 0;
            if (req.alt_form && op == OP_OCT && zeros == 0 && digit_ch[0] != CH_ZERO) begin
                zeros = 1;
            end
            plen = 0;
            if (req.alt_form && op >= OP_HEXL && !(nd == 1 && digit_ch[0] == CH_ZERO)) begin
                plen = 2;
            end

            width = int'(req.field_width);
            total = int'(has_sign) + plen + zeros + nd;
            if (req.zero_fill && !req.has_precision && !req.left_justify && width > total) begin
                zeros += width - total;
                total = width;
            end
            pad = (width > total) ? width - total : 0;

            if (!req.left_justify) begin
                repeat (pad) field.push_back(CH_SPACE);
            end
            if (has_sign) begin
                field.push_back(sign_ch);
            end
            if (plen != 0) begin
                field.push_back(CH_ZERO);
                field.push_back(CH_X + case_ofs);
            end
            repeat (zeros) field.push_back(CH_ZERO);
            foreach (digit_ch[i]) begin
                field.push_back(digit_ch[i]);
            end
            if (req.left_justify) begin
                repeat (pad) field.push_back(CH_SPACE);
            end

            n = (field.size() > IPF_MAX_FIELD) ? IPF_MAX_FIELD : field.size();
            for (int i = 0; i < n; i++) begin
                pending_chars.push_back('{out_char: field[i], last_char: logic'(i == n - 1)});
            end
        endfunction

        function void check_char(t_out got);
            t_out want;
            char_count++;
            if (pending_chars.size() == 0) begin
                report($sformatf("char %0d: unexpected transfer, char %h last %b",
                                 char_count, got.out_char, got.last_char));
            end else begin
                want = pending_chars.pop_front();
                if (got.out_char !== want.out_char) begin
                    report($sformatf("char %0d: out_char expected %h got %h",
                                     char_count, want.out_char, got.out_char));
                end
                if (got.last_char !== want.last_char) begin
                    report($sformatf("char %0d: last_char expected %b got %b",
                                     char_count, want.last_char, got.last_char));
                end
            end
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    format_scoreboard sb = new();

    int       idle_cycles = 0;
    t_rx_mode rx_mode     = RX_FREE;
    int       rx_span     = 0;

    integer_printf_formatter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.format_field(i_in_data);
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_char(o_out_data);
        end
    end

    // Receiver stall pattern: runs of free, light, heavy or toggling stalls.
    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_span <= $urandom_range(10, 120);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_FREE:  i_out_stall <= 1'b0;
            RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:  i_out_stall <= ~i_out_stall;
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic t_in make_request(logic [2:0] op, logic [1:0] sz, logic [63:0] val,
                                         int width, int prec, logic [4:0] flags);
        t_in req;
        req               = '0;
        req.op            = op;
        req.size_mode     = sz;
        req.value         = val;
        req.field_width   = 7'(width);
        req.has_precision = (prec != NO_PREC);
        req.min_digits    = (prec != NO_PREC) ? 6'(prec) : 6'd0;
        req.left_justify  = (flags & F_LEFT) != 0;
        req.force_sign    = (flags & F_PLUS) != 0;
        req.space_sign    = (flags & F_SPACE) != 0;
        req.alt_form      = (flags & F_ALT) != 0;
        req.zero_fill     = (flags & F_ZERO) != 0;
        return req;
    endfunction

    function automatic t_in random_request();
        t_in req;
        int  bit_pos;
        req = '0;
        if ($urandom_range(0, 9) == 0) begin
            req.op = 3'($urandom_range(int'(OP_HEXU) + 1, 7));
        end else begin
            req.op = 3'($urandom_range(int'(OP_SDEC), int'(OP_HEXU)));
        end
        req.size_mode = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0: req.value = 64'($urandom_range(0, 20));
            1: req.value = {$urandom, $urandom};
            2: begin
                // around the sign bit of some operand size, junk above it
                case ($urandom_range(0, 2))
                    0:       bit_pos = 15;
                    1:       bit_pos = 31;
                    default: bit_pos = 63;
                endcase
                req.value = (64'd1 << bit_pos) - 64'($urandom_range(0, 2));
                if (bit_pos < 63 && $urandom_range(0, 1) == 1) begin
                    req.value |= {$urandom, $urandom} << (bit_pos + 1);
                end
            end
            3: req.value = '1 - 64'($urandom_range(0, 3));
            default: req.value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        case ($urandom_range(0, 19))
            0:         req.field_width = 7'($urandom_range(65, 127));
            1, 2, 3:   req.field_width = 7'($urandom_range(25, 64));
            default:   req.field_width = 7'($urandom_range(0, 24));
        endcase
        req.has_precision = 1'($urandom_range(0, 1));
        req.min_digits    = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 12))
                                                       : 6'($urandom_range(0, 63));
        req.left_justify  = 1'($urandom_range(0, 1));
        req.force_sign    = 1'($urandom_range(0, 1));
        req.space_sign    = 1'($urandom_range(0, 1));
        req.alt_form      = 1'($urandom_range(0, 1));
        req.zero_fill     = 1'($urandom_range(0, 1));
        return req;
    endfunction

    task automatic send_request(input t_in req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // cycles must be at least 1 so valid never drops and rises in one step
    task automatic pause_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        t_in directed[$];
        int  sent;
        int  burst;

        directed.push_back(make_request(OP_SDEC, SZ_INT, 64'd0, 0, NO_PREC, F_NONE));
        directed.push_back(make_request(OP_SDEC, SZ_INT, 64'h8000_0000, 15, NO_PREC, F_NONE));
        directed.push_back(make_request(OP_SDEC, SZ_LONG, 64'h8000_0000_0000_0000, 0, NO_PREC,
                                        F_PLUS));
        directed.push_back(make_request(OP_UDEC, SZ_LONG, '1, 64, NO_PREC, F_PLUS | F_SPACE));
        directed.push_back(make_request(OP_OCT, SZ_LONG, '1, 0, NO_PREC, F_ALT));
        directed.push_back(make_request(OP_HEXL, SZ_INT, 64'hFFFF_FFFF_DEAD_BEEF, 20, NO_PREC,
                                        F_ALT | F_ZERO));
        directed.push_back(make_request(OP_HEXU, SZ_SHORT, 64'h1234_ABCD, 10, NO_PREC,
                                        F_ALT | F_LEFT));
        // zero printed even with precision zero
        directed.push_back(make_request(OP_SDEC, SZ_INT, 64'd0, 0, 0, F_NONE));
        directed.push_back(make_request(OP_UDEC, SZ_SHORT, 64'd42, 6, NO_PREC,
                                        F_PLUS | F_SPACE | F_ZERO));
        directed.push_back(make_request(OP_SDEC, SZ_INT, 64'd42, 0, NO_PREC, F_PLUS | F_SPACE));
        directed.push_back(make_request(OP_SDEC, SZ_INT, 64'hFFFF_FFFF_FFFF_FFFB, 10, 3,
                                        F_ZERO));
        directed.push_back(make_request(OP_SDEC, SZ_INT, 64'd7, 8, NO_PREC, F_ZERO | F_LEFT));
        directed.push_back(make_request(OP_OCT, SZ_INT, 64'd0, 0, NO_PREC, F_ALT));
        directed.push_back(make_request(OP_OCT, SZ_INT, 64'd8, 0, 5, F_ALT));
        directed.push_back(make_request(OP_OCT, SZ_INT, 64'd8, 0, 2, F_ALT));
        directed.push_back(make_request(OP_HEXL, SZ_INT, 64'd0, 5, NO_PREC, F_ALT));
        directed.push_back(make_request(OP_HEXU + 3'd1, SZ_INT, 64'hABCD, 0, NO_PREC, F_ALT));
        directed.push_back(make_request(OP_HEXU + 3'd2, SZ_SHORT, 64'hFACE, 0, NO_PREC, F_NONE));
        directed.push_back(make_request(OP_HEXU + 3'd3, SZ_LONG, 64'h1F, 8, NO_PREC, F_ZERO));
        directed.push_back(make_request(OP_HEXL, SZ_UNKNOWN, 64'hFEDC_BA98_7654_3210, 0, NO_PREC,
                                        F_ALT));
        // fields past the character limit get cut
        directed.push_back(make_request(OP_SDEC, SZ_INT, 64'd1, 127, NO_PREC, F_NONE));
        directed.push_back(make_request(OP_SDEC, SZ_INT, 64'd12345, 127, NO_PREC, F_LEFT));
        directed.push_back(make_request(OP_HEXL, SZ_LONG, 64'hABC, 0, 63, F_ALT));
        directed.push_back(make_request(OP_SDEC, SZ_INT, 64'd5, 6, NO_PREC, F_SPACE | F_ZERO));
        directed.push_back(make_request(OP_SDEC, SZ_SHORT, 64'h1234_5678_9ABC_FFFF, 0, NO_PREC,
                                        F_NONE));
        directed.push_back(make_request(OP_SDEC, SZ_SHORT, 64'h8000, 8, NO_PREC,
                                        F_PLUS | F_ZERO));
        directed.push_back(make_request(OP_HEXL, SZ_INT, 64'hBEEF, 12, NO_PREC, F_ALT | F_ZERO));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_request(directed[i]);
            if ($urandom_range(0, 3) == 0) begin
                pause_sender($urandom_range(1, 10));
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_request(random_request());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                pause_sender($urandom_range(1, 20));
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
